FILE: hw/rtl/assert_macros.svh
// Concurrent assertion helpers; clk and rst must be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/ihp_pkg.sv
`timescale 1ns / 1ps

package ihp_pkg;

  localparam int ID_W     = 8;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd3;

  // operand selection of the shared key comparator
  localparam logic [1:0] CMP_CUR_RD   = 2'd0;
  localparam logic [1:0] CMP_RD_CAND  = 2'd1;
  localparam logic [1:0] CMP_CAND_CUR = 2'd2;

endpackage

FILE: hw/rtl/ihp_if.sv
`timescale 1ns / 1ps

interface ihp_req_if;
  import ihp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [ID_W-1:0]         node_id;
  logic signed [KEY_W-1:0] key_value;

  modport source (output valid, output cmd, output node_id, output key_value, input ready);
  modport sink (input valid, input cmd, input node_id, input key_value, output ready);
endinterface

interface ihp_rsp_if;
  import ihp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [ID_W-1:0]         top_node;
  logic signed [KEY_W-1:0] top_key;
  logic [COUNT_W-1:0]      entry_count;
  logic                    is_empty;

  modport source (output valid, output status, output top_node, output top_key,
                  output entry_count, output is_empty, input ready);
  modport sink (input valid, input status, input top_node, input top_key,
                input entry_count, input is_empty, output ready);
endinterface

FILE: hw/rtl/ihp_ram.sv
`timescale 1ns / 1ps

module ihp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/ihp_key_cmp.sv
`timescale 1ns / 1ps

module ihp_key_cmp #(
  parameter int KW = 32
) (
  input  logic [1:0]    sel,
  input  logic [KW-1:0] cur_key,
  input  logic [KW-1:0] cand_key,
  input  logic [KW-1:0] rd_key,
  output logic          gt
);
  import ihp_pkg::*;

  logic signed [KW-1:0] op_a;
  logic signed [KW-1:0] op_b;

  always_comb begin
    unique case (sel)
      CMP_CUR_RD: begin
        op_a = cur_key;
        op_b = rd_key;
      end
      CMP_RD_CAND: begin
        op_a = rd_key;
        op_b = cand_key;
      end
      CMP_CAND_CUR: begin
        op_a = cand_key;
        op_b = cur_key;
      end
      default: begin
        op_a = cur_key;
        op_b = cur_key;
      end
    endcase
  end

  assign gt = op_a > op_b;

endmodule

FILE: hw/rtl/indexed_max_heap_top.sv
`timescale 1ns / 1ps
// Indexed binary max-heap of up to MAX_NODES node ids keyed by signed KEY_BITS-bit keys.
// Each request inserts a node with its key or deletes a node by id and returns one
// response with a status, the root node and key, the count and an empty flag. One
// request is worked on at a time; req.ready is high only while the sequencer is idle,
// and a finished response waits in an output register. Heap slots live in a single
// port-pair RAM with registered read, so every tree level costs memory reads. A
// refused request goes straight to its response; an accepted insert or delete sifts
// the moved entry up and then down the tree, unless the delete removed the last slot.
// All key compares go through one shared comparator.
// The node presence bits are flip-flops cleared at reset, so no clearing pass is needed.

`include "assert_macros.svh"

module indexed_max_heap_top #(
  parameter int MAX_NODES = 256,
  parameter int KEY_BITS  = 32
) (
  input logic   clk,
  input logic   rst,
  ihp_req_if.sink   req,
  ihp_rsp_if.source rsp
);
  import ihp_pkg::*;

  localparam int KW = KEY_BITS;
  localparam int SW = $clog2(MAX_NODES);
  localparam int FW = $clog2(MAX_NODES + 1);
  localparam int CW = SW + 2;
  localparam int ND = (MAX_NODES < 256) ? MAX_NODES : 256;
  localparam int NW = $clog2(ND);
  localparam int DW = NW + KW;
  localparam bit KEY_WIDE = KEY_BITS > KEY_W;
  localparam logic [ID_W:0] ID_LIMIT = (ID_W + 1)'(ND);
  localparam logic [FW-1:0] FILL_FULL = FW'(MAX_NODES);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DL_POS  = 4'd1;
  localparam logic [3:0] S_DL_LAST = 4'd2;
  localparam logic [3:0] S_UP_CHK  = 4'd3;
  localparam logic [3:0] S_UP_CMP  = 4'd4;
  localparam logic [3:0] S_SK_CHK  = 4'd5;
  localparam logic [3:0] S_SK_L    = 4'd6;
  localparam logic [3:0] S_SK_R    = 4'd7;
  localparam logic [3:0] S_SK_CMP  = 4'd8;
  localparam logic [3:0] S_FIN     = 4'd9;

  logic [3:0]    state, state_next;
  logic [FW-1:0] fill, fill_next;
  logic [ND-1:0] held, held_next;
  logic [SW-1:0] pos, pos_next;
  logic [NW-1:0] cur_node, cur_node_next;
  logic [KW-1:0] cur_key, cur_key_next;
  logic [NW-1:0] cand_node, cand_node_next;
  logic [KW-1:0] cand_key, cand_key_next;
  logic [SW-1:0] cand_idx, cand_idx_next;
  logic [STATUS_W-1:0] status, status_next;
  logic [NW-1:0] root_node;
  logic [KW-1:0] root_key;
  logic out_valid, out_valid_next;
  logic out_load;

  logic [STATUS_W-1:0]     rsp_status;
  logic [ID_W-1:0]         rsp_node;
  logic signed [KEY_W-1:0] rsp_key;
  logic [COUNT_W-1:0]      rsp_count;
  logic                    rsp_empty;

  logic          wr_en, rd_en;
  logic [SW-1:0] wr_addr, rd_addr;
  logic [DW-1:0] wr_data, rd_data;
  logic          pwr_en, prd_en;
  logic [NW-1:0] pwr_addr, prd_addr;
  logic [SW-1:0] pwr_data, prd_data;

  logic [1:0]    cmp_sel;
  logic          cmp_gt;
  logic [NW-1:0] rd_node;
  logic [KW-1:0] rd_key;
  logic [KW-1:0] key_in;
  logic [NW-1:0] req_idx;
  logic          id_ok;
  logic [CW-1:0] l_idx, r_idx, fill_c;
  logic [SW-1:0] parent;
  logic signed [KW-1:0] root_key_s;

  ihp_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ihp_ram #(.WIDTH(SW), .DEPTH(ND)) u_pos_ram (
    .clk     (clk),
    .wr_en   (pwr_en),
    .wr_addr (pwr_addr),
    .wr_data (pwr_data),
    .rd_en   (prd_en),
    .rd_addr (prd_addr),
    .rd_data (prd_data)
  );

  ihp_key_cmp #(.KW(KW)) u_cmp (
    .sel      (cmp_sel),
    .cur_key  (cur_key),
    .cand_key (cand_key),
    .rd_key   (rd_key),
    .gt       (cmp_gt)
  );

  assign rd_node = rd_data[DW-1:KW];
  assign rd_key  = rd_data[KW-1:0];
  assign req_idx = req.node_id[NW-1:0];
  assign id_ok   = {1'b0, req.node_id} < ID_LIMIT;
  assign l_idx   = CW'({pos, 1'b1});
  assign r_idx   = l_idx + CW'(1);
  assign fill_c  = CW'(fill);
  assign parent  = (pos - SW'(1)) >> 1;
  assign root_key_s = root_key;

  always_comb begin
    if (KEY_WIDE) begin
      key_in = KW'($unsigned(req.key_value));
    end else begin
      key_in = KW'(req.key_value);
    end
  end

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    held_next      = held;
    pos_next       = pos;
    cur_node_next  = cur_node;
    cur_key_next   = cur_key;
    cand_node_next = cand_node;
    cand_key_next  = cand_key;
    cand_idx_next  = cand_idx;
    status_next    = status;
    out_valid_next = out_valid && !rsp.ready;
    out_load       = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = pos;
    wr_data  = {cur_node, cur_key};
    rd_en    = 1'b0;
    rd_addr  = '0;
    pwr_en   = 1'b0;
    pwr_addr = cur_node;
    pwr_data = pos;
    prd_en   = 1'b0;
    prd_addr = req_idx;
    cmp_sel  = CMP_CUR_RD;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_FIN;
          if (req.cmd == CMD_INSERT) begin
            if (!id_ok || fill == FILL_FULL) begin
              status_next = ST_FULL;
            end else if (held[req_idx]) begin
              status_next = ST_PRESENT;
            end else begin
              status_next        = ST_OK;
              fill_next          = fill + FW'(1);
              held_next[req_idx] = 1'b1;
              pos_next           = fill[SW-1:0];
              cur_node_next      = req_idx;
              cur_key_next       = key_in;
              state_next         = S_UP_CHK;
            end
          end else begin
            if (!id_ok || !held[req_idx] || fill == '0) begin
              status_next = ST_ABSENT;
            end else begin
              status_next        = ST_OK;
              fill_next          = fill - FW'(1);
              held_next[req_idx] = 1'b0;
              prd_en             = 1'b1;
              state_next         = S_DL_POS;
            end
          end
        end
      end
      S_DL_POS: begin
        pos_next = prd_data;
        if (CW'(prd_data) < fill_c) begin
          rd_en      = 1'b1;
          rd_addr    = fill[SW-1:0];
          state_next = S_DL_LAST;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DL_LAST: begin
        cur_node_next = rd_node;
        cur_key_next  = rd_key;
        state_next    = S_UP_CHK;
      end
      S_UP_CHK: begin
        if (pos == '0) begin
          state_next = S_SK_CHK;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = parent;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmp_sel = CMP_CUR_RD;
        if (cmp_gt) begin
          // parent moves down into the hole
          wr_en      = 1'b1;
          wr_data    = rd_data;
          pwr_en     = 1'b1;
          pwr_addr   = rd_node;
          pos_next   = parent;
          state_next = S_UP_CHK;
        end else begin
          state_next = S_SK_CHK;
        end
      end
      S_SK_CHK: begin
        if (l_idx >= fill_c) begin
          wr_en      = 1'b1;
          pwr_en     = 1'b1;
          state_next = S_FIN;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = l_idx[SW-1:0];
          state_next = S_SK_L;
        end
      end
      S_SK_L: begin
        cand_node_next = rd_node;
        cand_key_next  = rd_key;
        cand_idx_next  = l_idx[SW-1:0];
        if (r_idx < fill_c) begin
          rd_en      = 1'b1;
          rd_addr    = r_idx[SW-1:0];
          state_next = S_SK_R;
        end else begin
          state_next = S_SK_CMP;
        end
      end
      S_SK_R: begin
        // right child only on strictly greater key
        cmp_sel = CMP_RD_CAND;
        if (cmp_gt) begin
          cand_node_next = rd_node;
          cand_key_next  = rd_key;
          cand_idx_next  = r_idx[SW-1:0];
        end
        state_next = S_SK_CMP;
      end
      S_SK_CMP: begin
        cmp_sel = CMP_CAND_CUR;
        pwr_en  = 1'b1;
        wr_en   = 1'b1;
        if (cmp_gt) begin
          wr_data    = {cand_node, cand_key};
          pwr_addr   = cand_node;
          pos_next   = cand_idx;
          state_next = S_SK_CHK;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid || rsp.ready) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      held      <= held_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pos       <= pos_next;
    cur_node  <= cur_node_next;
    cur_key   <= cur_key_next;
    cand_node <= cand_node_next;
    cand_key  <= cand_key_next;
    cand_idx  <= cand_idx_next;
    status    <= status_next;
    if (wr_en && wr_addr == '0) begin
      root_node <= wr_data[DW-1:KW];
      root_key  <= wr_data[KW-1:0];
    end
    if (out_load) begin
      rsp_status <= status;
      rsp_count  <= COUNT_W'(fill);
      rsp_empty  <= fill == '0;
      if (fill == '0) begin
        rsp_node <= '0;
        rsp_key  <= '0;
      end else begin
        rsp_node <= ID_W'(root_node);
        rsp_key  <= KEY_W'(root_key_s);
      end
    end
  end

  assign req.ready       = state == S_IDLE;
  assign rsp.valid       = out_valid;
  assign rsp.status      = rsp_status;
  assign rsp.top_node    = rsp_node;
  assign rsp.top_key     = rsp_key;
  assign rsp.entry_count = rsp_count;
  assign rsp.is_empty    = rsp_empty;

  `ASSERT_NOW(a_fill_matches_held, 1'b1, $countones(held) == int'(fill), "held bits vs count")
  `ASSERT_NOW(a_fill_bound, 1'b1, fill <= FILL_FULL, "count above capacity")
  `ASSERT_NOW(a_pos_in_heap, (state == S_UP_CHK) || (state == S_SK_CHK), CW'(pos) < fill_c, "slot outside heap")
  `ASSERT_NEXT(a_refused_keeps_fill, (state == S_IDLE) && req.valid && (state_next == S_FIN), $stable(fill), "refused request changed count")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ihp_pkg::*;

  localparam int HEAP_SLOTS  = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 100;

  typedef struct packed {
    logic                    cmd;
    logic [ID_W-1:0]         node_id;
    logic signed [KEY_W-1:0] key_value;
  } heap_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [ID_W-1:0]         top_node;
    logic signed [KEY_W-1:0] top_key;
    logic [COUNT_W-1:0]      entry_count;
    logic                    is_empty;
  } heap_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ihp_req_if req_ch ();
  ihp_rsp_if rsp_ch ();

  indexed_max_heap_top #(
    .MAX_NODES(HEAP_SLOTS),
    .KEY_BITS (KEY_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #5 clk = ~clk;

  // predicted heap contents
  logic [ID_W-1:0]         heap_node [HEAP_SLOTS];
  logic signed [KEY_W-1:0] heap_key  [HEAP_SLOTS];
  int unsigned             node_pos  [HEAP_SLOTS];
  bit                      node_in   [HEAP_SLOTS];
  int unsigned             heap_fill;

  // presence tracking while building the request list
  bit                      gen_in [HEAP_SLOTS];
  int unsigned             gen_fill;

  heap_req_t pending_reqs[$];
  heap_rsp_t expected_rsp[$];
  heap_req_t taken_req;
  heap_req_t next_req;
  heap_rsp_t want_rsp;
  heap_rsp_t got_rsp;

  int  total_reqs;
  int  req_taken;
  int  mismatches;
  int  cycle_count;
  int  hold_left;
  bit  hold_done;
  logic calm;

  assign calm = (req_taken >= 700) && (req_taken < 1000);

  function automatic void slot_swap(int unsigned a, int unsigned b);
    logic [ID_W-1:0]         tn;
    logic signed [KEY_W-1:0] tk;
    tn = heap_node[a];
    tk = heap_key[a];
    heap_node[a] = heap_node[b];
    heap_key[a]  = heap_key[b];
    heap_node[b] = tn;
    heap_key[b]  = tk;
    node_pos[heap_node[a]] = a;
    node_pos[heap_node[b]] = b;
  endfunction

  function automatic int unsigned sift_up(int unsigned p);
    int unsigned up;
    bit          done;
    done = 1'b0;
    while (p > 0 && !done) begin
      up = (p - 1) / 2;
      if (heap_key[p] > heap_key[up]) begin
        slot_swap(p, up);
        p = up;
      end else begin
        done = 1'b1;
      end
    end
    return p;
  endfunction

  function automatic void sift_down(int unsigned p);
    int unsigned l, r, pick;
    bit          done;
    done = 1'b0;
    while (!done) begin
      l = 2 * p + 1;
      r = l + 1;
      if (l >= heap_fill) begin
        done = 1'b1;
      end else if (r >= heap_fill) begin
        if (heap_key[l] > heap_key[p]) begin
          slot_swap(p, l);
          p = l;
        end else begin
          done = 1'b1;
        end
      end else begin
        if (!(heap_key[r] > heap_key[l]) && (heap_key[l] > heap_key[p])) begin
          pick = l;
        end else if ((heap_key[r] > heap_key[l]) && (heap_key[r] > heap_key[p])) begin
          pick = r;
        end else begin
          done = 1'b1;
        end
        if (!done) begin
          slot_swap(p, pick);
          p = pick;
        end
      end
    end
  endfunction

  function automatic heap_rsp_t heap_apply(heap_req_t r);
    heap_rsp_t   res;
    int unsigned p, last;
    res.status = ST_OK;
    if (r.cmd == CMD_INSERT) begin
      if (heap_fill >= HEAP_SLOTS) begin
        res.status = ST_FULL;
      end else if (node_in[r.node_id]) begin
        res.status = ST_PRESENT;
      end else begin
        p = heap_fill;
        heap_fill++;
        heap_node[p] = r.node_id;
        heap_key[p]  = r.key_value;
        node_pos[r.node_id] = p;
        node_in[r.node_id]  = 1'b1;
        void'(sift_up(p));
      end
    end else begin
      if (!node_in[r.node_id] || heap_fill == 0) begin
        res.status = ST_ABSENT;
      end else begin
        p = node_pos[r.node_id];
        last = heap_fill - 1;
        node_in[r.node_id] = 1'b0;
        heap_fill = last;
        if (p < last) begin
          heap_node[p] = heap_node[last];
          heap_key[p]  = heap_key[last];
          node_pos[heap_node[p]] = p;
          p = sift_up(p);
          sift_down(p);
        end
      end
    end
    if (heap_fill == 0) begin
      res.top_node = '0;
      res.top_key  = '0;
      res.is_empty = 1'b1;
    end else begin
      res.top_node = heap_node[0];
      res.top_key  = heap_key[0];
      res.is_empty = 1'b0;
    end
    res.entry_count = COUNT_W'(heap_fill);
    return res;
  endfunction

  task automatic push_req(logic cmd, logic [ID_W-1:0] id, logic signed [KEY_W-1:0] key);
    heap_req_t r;
    r.cmd = cmd;
    r.node_id = id;
    r.key_value = key;
    pending_reqs.push_back(r);
    if (cmd == CMD_INSERT) begin
      if (gen_fill < HEAP_SLOTS && !gen_in[id]) begin
        gen_in[id] = 1'b1;
        gen_fill++;
      end
    end else if (gen_in[id]) begin
      gen_in[id] = 1'b0;
      gen_fill--;
    end
  endtask

  function automatic logic [ID_W-1:0] find_id(bit want_in);
    int unsigned start, id;
    start = $urandom_range(HEAP_SLOTS - 1);
    for (int i = 0; i < HEAP_SLOTS; i++) begin
      id = (start + i) % HEAP_SLOTS;
      if (gen_in[id] == want_in) return id[ID_W-1:0];
    end
    return start[ID_W-1:0];
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_key(bit narrow);
    int unsigned r;
    int          k;
    r = $urandom_range(99);
    if (narrow && r < 50) begin
      k = $urandom_range(6);
      return k - 3;
    end
    if (r < 60) begin
      case ($urandom_range(3))
        0: return 32'sh7fff_ffff;
        1: return 32'sh8000_0000;
        2: return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  task automatic mix_phase(int n, int ins_pct, bit narrow);
    logic [ID_W-1:0] id;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < ins_pct) begin
        id = ($urandom_range(99) < 90) ? find_id(1'b0) : find_id(1'b1);
        push_req(CMD_INSERT, id, pick_key(narrow));
      end else begin
        id = ($urandom_range(99) < 85) ? find_id(1'b1) : ID_W'($urandom_range(255));
        push_req(CMD_DELETE, id, $urandom);
      end
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_taken    <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        taken_req.cmd       = req_ch.cmd;
        taken_req.node_id   = req_ch.node_id;
        taken_req.key_value = req_ch.key_value;
        expected_rsp.push_back(heap_apply(taken_req));
        req_taken <= req_taken + 1;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
          next_req = pending_reqs.pop_front();
          req_ch.cmd       <= next_req.cmd;
          req_ch.node_id   <= next_req.node_id;
          req_ch.key_value <= next_req.key_value;
          req_ch.valid     <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long output stall so the block backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && req_taken >= 300) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // response monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got_rsp.status      = rsp_ch.status;
        got_rsp.top_node    = rsp_ch.top_node;
        got_rsp.top_key     = rsp_ch.top_key;
        got_rsp.entry_count = rsp_ch.entry_count;
        got_rsp.is_empty    = rsp_ch.is_empty;
        if (expected_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected response: status=%0d node=%0d key=%0d count=%0d empty=%0d",
                     got_rsp.status, got_rsp.top_node, got_rsp.top_key,
                     got_rsp.entry_count, got_rsp.is_empty);
        end else begin
          want_rsp = expected_rsp.pop_front();
          if (got_rsp !== want_rsp) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("mismatch: exp status=%0d node=%0d key=%0d count=%0d empty=%0d",
                     want_rsp.status, want_rsp.top_node, want_rsp.top_key,
                     want_rsp.entry_count, want_rsp.is_empty);
              $display(" | got status=%0d node=%0d key=%0d count=%0d empty=%0d",
                       got_rsp.status, got_rsp.top_node, got_rsp.top_key,
                       got_rsp.entry_count, got_rsp.is_empty);
            end
          end
        end
      end
      rsp_ch.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 6);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    req_ch.valid     = 1'b0;
    req_ch.cmd       = CMD_INSERT;
    req_ch.node_id   = '0;
    req_ch.key_value = '0;
    rsp_ch.ready     = 1'b0;
    mismatches  = 0;
    cycle_count = 0;
    heap_fill   = 0;
    gen_fill    = 0;
    for (int i = 0; i < HEAP_SLOTS; i++) begin
      node_in[i] = 1'b0;
      gen_in[i]  = 1'b0;
    end

    // directed: empty heap, extremes, duplicates, ties, root/last/middle deletes
    push_req(CMD_DELETE, 8'd5,   32'sh0);
    push_req(CMD_INSERT, 8'd0,   32'sh7fff_ffff);
    push_req(CMD_INSERT, 8'd255, 32'sh8000_0000);
    push_req(CMD_INSERT, 8'd0,   32'sh1234_5678);
    push_req(CMD_INSERT, 8'd7,   32'sh0);
    push_req(CMD_INSERT, 8'd8,   32'sh7fff_ffff);
    push_req(CMD_INSERT, 8'd9,   -32'sd1);
    push_req(CMD_INSERT, 8'd10,  32'sh7fff_ffff);
    push_req(CMD_DELETE, 8'd0,   32'shffff_ffff);
    push_req(CMD_DELETE, 8'd10,  32'sh0);
    push_req(CMD_DELETE, 8'd255, 32'sh0);
    push_req(CMD_DELETE, 8'd255, 32'sh0);
    push_req(CMD_INSERT, 8'd128, 32'sh0000_0001);
    push_req(CMD_INSERT, 8'd127, 32'sh7fff_fffe);
    push_req(CMD_INSERT, 8'd3,   -32'sd1);
    push_req(CMD_DELETE, 8'd9,   32'sh0);
    push_req(CMD_DELETE, 8'd128, 32'sh0);
    push_req(CMD_DELETE, 8'd7,   32'sh0);
    push_req(CMD_DELETE, 8'd8,   32'sh0);
    push_req(CMD_DELETE, 8'd127, 32'sh0);
    push_req(CMD_DELETE, 8'd3,   32'sh0);
    push_req(CMD_DELETE, 8'd3,   32'sh0);

    mix_phase(450, 60, 1'b0);
    while (gen_fill < HEAP_SLOTS) push_req(CMD_INSERT, find_id(1'b0), pick_key(1'b1));
    push_req(CMD_INSERT, find_id(1'b1), pick_key(1'b0));
    push_req(CMD_INSERT, 8'd0, 32'sh7fff_ffff);
    push_req(CMD_INSERT, 8'd255, 32'sh8000_0000);
    push_req(CMD_DELETE, find_id(1'b1), 32'sh0);
    push_req(CMD_INSERT, find_id(1'b0), 32'sh7fff_ffff);
    push_req(CMD_INSERT, find_id(1'b0), pick_key(1'b0));
    mix_phase(300, 20, 1'b0);
    mix_phase(450, 55, 1'b1);
    while (gen_fill > 0) push_req(CMD_DELETE, find_id(1'b1), $urandom);
    push_req(CMD_DELETE, ID_W'($urandom_range(255)), $urandom);
    total_reqs = pending_reqs.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (req_taken != total_reqs) @(posedge clk);
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0 && expected_rsp.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/ihp_pkg.sv
hw/rtl/ihp_if.sv
hw/rtl/ihp_ram.sv
hw/rtl/ihp_key_cmp.sv
hw/rtl/indexed_max_heap_top.sv
tb/tb_top.sv
